@@ src/square_matrix_multiply_accumulate_top_defines.svh @@
// Assertion macros used by the checker of the matrix multiply-accumulate block.
`ifndef SQUARE_MATRIX_MULTIPLY_ACCUMULATE_TOP_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_ACCUMULATE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMMA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/smma_pkg.sv @@
// Shared constants and control/status types of the matrix multiply-accumulate block.
`default_nettype none

package smma_pkg;

  localparam int unsigned SizeW          = 4;
  localparam int unsigned DefaultMaxSize = 8;
  localparam int unsigned SizeReset      = 8;
  localparam int unsigned StoreDepth     = 64;
  localparam int unsigned AddrW          = $clog2(StoreDepth);
  localparam int unsigned ElemW          = 16;
  localparam int unsigned SumW           = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_we;
    logic [AddrW-1:0] load_addr;
    logic             issue;
    logic             first;
    logic             last;
    logic             final_elem;
    logic [AddrW-1:0] a_addr;
    logic [AddrW-1:0] b_addr;
    logic [AddrW-1:0] c_addr;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic final_done;
  } sts_t;

endpackage

`default_nettype wire

@@ src/smma_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module smma_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/smma_ctrl.sv @@
// Controller: load sequencing, size register and the i/j/k loop counters.
`default_nettype none

module smma_ctrl #(
  parameter int unsigned MaxSize = smma_pkg::DefaultMaxSize
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        last_element_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [smma_pkg::SizeW-1:0]  cfg_data_i,
  input  wire smma_pkg::sts_t              sts_i,
  output smma_pkg::cmd_t                   cmd_o,
  output logic                             busy_o
);

  localparam int unsigned CntW  = $clog2(MaxSize + 1);
  localparam int unsigned SizeW = smma_pkg::SizeW;
  localparam int unsigned AddrW = smma_pkg::AddrW;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRun   = 3'b010,
    StDrain = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SizeW-1:0]  size_q;
  logic [AddrW-1:0]  load_idx_q, load_idx_d;
  logic [CntW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic [AddrW-1:0]  row_q, row_d, kb_q, kb_d;
  logic [SizeW-1:0]  n_eff, n_m1;
  logic [AddrW-1:0]  n_addr;
  logic              k_end, j_end, i_end;

  // Clamp the size register into 1..MaxSize.
  always_comb begin
    n_eff = size_q;
    if (size_q == '0) begin
      n_eff = SizeW'(1);
    end else if (size_q > SizeW'(MaxSize)) begin
      n_eff = SizeW'(MaxSize);
    end
  end

  assign n_m1   = n_eff - SizeW'(1);
  assign n_addr = AddrW'(n_eff);
  assign k_end  = (SizeW'(k_q) == n_m1);
  assign j_end  = (SizeW'(j_q) == n_m1);
  assign i_end  = (SizeW'(i_q) == n_m1);

  always_comb begin
    state_d    = state_q;
    load_idx_d = load_idx_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    row_d      = row_q;
    kb_d       = kb_q;

    cmd_o            = '0;
    cmd_o.load_addr  = load_idx_q;
    cmd_o.a_addr     = row_q + AddrW'(k_q);
    cmd_o.b_addr     = kb_q + AddrW'(j_q);
    cmd_o.c_addr     = row_q + AddrW'(j_q);
    cmd_o.first      = (k_q == '0);
    cmd_o.last       = k_end;
    cmd_o.final_elem = k_end && j_end && i_end;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load_we = 1'b1;
          if (last_element_i) begin
            load_idx_d = '0;
            i_d        = '0;
            j_d        = '0;
            k_d        = '0;
            row_d      = '0;
            kb_d       = '0;
            state_d    = StRun;
          end else begin
            load_idx_d = load_idx_q + AddrW'(1);
          end
        end
      end
      StRun: begin
        cmd_o.issue = 1'b1;
        if (k_end) begin
          k_d  = '0;
          kb_d = '0;
          if (j_end) begin
            j_d   = '0;
            i_d   = i_q + CntW'(1);
            row_d = row_q + n_addr;
            if (i_end) begin
              state_d = StDrain;
            end
          end else begin
            j_d = j_q + CntW'(1);
          end
        end else begin
          k_d  = k_q + CntW'(1);
          kb_d = kb_q + n_addr;
        end
      end
      StDrain: begin
        if (sts_i.final_done) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      size_q     <= SizeW'(smma_pkg::SizeReset);
      load_idx_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      row_q      <= '0;
      kb_q       <= '0;
    end else begin
      state_q    <= state_d;
      load_idx_q <= load_idx_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      row_q      <= row_d;
      kb_q       <= kb_d;
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

`default_nettype wire

@@ src/smma_dp.sv @@
// Datapath: element stores, multiplier and accumulator pipeline, write-back.
`default_nettype none

module smma_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire smma_pkg::cmd_t                    cmd_i,
  input  wire logic signed [smma_pkg::ElemW-1:0] left_element_i,
  input  wire logic signed [smma_pkg::ElemW-1:0] right_element_i,
  input  wire logic signed [smma_pkg::SumW-1:0]  initial_sum_i,
  output smma_pkg::sts_t                         sts_o,
  output logic                                   result_valid_o,
  output logic signed [smma_pkg::SumW-1:0]       product_element_o,
  output logic                                   last_result_o
);

  localparam int unsigned AddrW = smma_pkg::AddrW;
  localparam int unsigned ElemW = smma_pkg::ElemW;
  localparam int unsigned SumW  = smma_pkg::SumW;
  localparam int unsigned Depth = smma_pkg::StoreDepth;

  logic [ElemW-1:0] a_rdata, b_rdata;
  logic [SumW-1:0]  c_rdata;

  logic             sum_we;
  logic [AddrW-1:0] sum_waddr;
  logic [SumW-1:0]  sum_wdata;

  // Stage 1: store read data is valid.
  logic             s1_valid_q, s1_first_q, s1_last_q, s1_final_q;
  logic [AddrW-1:0] s1_ci_q;
  // Stage 2: product registered.
  logic             s2_valid_q, s2_first_q, s2_last_q, s2_final_q;
  logic [AddrW-1:0] s2_ci_q;
  logic [SumW-1:0]  s2_c_q;
  logic signed [SumW-1:0] prod_q, prod_d;
  // Stage 3: accumulator.
  logic             s3_valid_q, s3_last_q, s3_final_q;
  logic [AddrW-1:0] s3_ci_q;
  logic [SumW-1:0]  acc_q, acc_d;
  logic             wb_we;

  assign wb_we     = s3_valid_q && s3_last_q;
  assign sum_we    = cmd_i.load_we || wb_we;
  assign sum_waddr = wb_we ? s3_ci_q : cmd_i.load_addr;
  assign sum_wdata = wb_we ? acc_q : initial_sum_i;

  smma_ram #(.Width(ElemW), .Depth(Depth)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we),
    .waddr_i (cmd_i.load_addr),
    .wdata_i (left_element_i),
    .raddr_i (cmd_i.a_addr),
    .rdata_o (a_rdata)
  );

  smma_ram #(.Width(ElemW), .Depth(Depth)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we),
    .waddr_i (cmd_i.load_addr),
    .wdata_i (right_element_i),
    .raddr_i (cmd_i.b_addr),
    .rdata_o (b_rdata)
  );

  smma_ram #(.Width(SumW), .Depth(Depth)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (cmd_i.c_addr),
    .rdata_o (c_rdata)
  );

  assign prod_d = $signed(a_rdata) * $signed(b_rdata);
  // Seed with the stored sum on the first product of an element; wrap on overflow.
  assign acc_d  = (s2_first_q ? s2_c_q : acc_q) + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s1_final_q <= cmd_i.final_elem;
    s1_ci_q    <= cmd_i.c_addr;

    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_final_q <= s1_final_q;
    s2_ci_q    <= s1_ci_q;
    s2_c_q     <= c_rdata;
    prod_q     <= prod_d;

    s3_last_q  <= s2_last_q;
    s3_final_q <= s2_final_q;
    s3_ci_q    <= s2_ci_q;
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
  end

  assign result_valid_o    = wb_we;
  assign product_element_o = acc_q;
  assign last_result_o     = wb_we && s3_final_q;
  assign sts_o.final_done  = wb_we && s3_final_q;

endmodule

`default_nettype wire

@@ src/square_matrix_multiply_accumulate_top.sv @@
// Top level of the square matrix multiply-accumulate block: controller plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | start_i, busy_o      | left_element_i, right_element_i,
//           |                      | initial_sum_i, last_element_i
//  result   | result_valid_o       | product_element_o, last_result_o
//  config   | cfg_we_i             | cfg_data_i (size_in_use)
//
// A load transaction is accepted when start_i is high and busy_o low.
// After the transaction marked last, busy_o stays high until the final result is shown,
// with one multiply-accumulate per cycle on the single MAC pipeline (store read,
// multiply, accumulate).
// Each result is shown for one cycle with result_valid_o.
// Reset (rst_ni low, asynchronous) sets size_in_use to 8 and the load index to 0;
// store contents are not cleared, so an entry must be loaded before it is used.
// The receiver cannot stall results; cfg_we_i should only be used while busy_o is low.
`default_nettype none

module square_matrix_multiply_accumulate_top #(
  parameter int unsigned MaxSize = smma_pkg::DefaultMaxSize
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic signed [smma_pkg::ElemW-1:0] left_element_i,
  input  wire logic signed [smma_pkg::ElemW-1:0] right_element_i,
  input  wire logic signed [smma_pkg::SumW-1:0]  initial_sum_i,
  input  wire logic                              last_element_i,
  output logic                                   result_valid_o,
  output logic signed [smma_pkg::SumW-1:0]       product_element_o,
  output logic                                   last_result_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [smma_pkg::SizeW-1:0]        cfg_data_i
);

  smma_pkg::cmd_t cmd;
  smma_pkg::sts_t sts;

  // Sequence loads and the i/j/k loops; hold busy until the last result leaves.
  smma_ctrl #(.MaxSize(MaxSize)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .last_element_i (last_element_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy_o)
  );

  // Store the matrices, run the MAC pipeline and write each sum back.
  smma_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .left_element_i    (left_element_i),
    .right_element_i   (right_element_i),
    .initial_sum_i     (initial_sum_i),
    .sts_o             (sts),
    .result_valid_o    (result_valid_o),
    .product_element_o (product_element_o),
    .last_result_o     (last_result_o)
  );

endmodule

`default_nettype wire

@@ src/smma_checker.sv @@
// Port-level checker of the matrix multiply-accumulate block and its bind.
`default_nettype none
`include "square_matrix_multiply_accumulate_top_defines.svh"

module smma_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic last_element_i,
  input wire logic result_valid_o,
  input wire logic last_result_o
);

  `SMMA_ASSERT_IMPLY(a_result_while_busy, clk_i, rst_ni, result_valid_o, busy_o, "result outside a compute")
  `SMMA_ASSERT_IMPLY(a_final_is_result, clk_i, rst_ni, last_result_o, result_valid_o, "final mark without result")
  `SMMA_ASSERT_NEXT(a_last_starts, clk_i, rst_ni, start_i && !busy_o && last_element_i, busy_o, "compute did not start")
  `SMMA_ASSERT_NEXT(a_load_stays_idle, clk_i, rst_ni, start_i && !busy_o && !last_element_i, !busy_o, "busy after plain load")
  `SMMA_ASSERT_NEXT(a_final_frees, clk_i, rst_ni, result_valid_o && last_result_o, !busy_o, "busy after final result")

endmodule

bind square_matrix_multiply_accumulate_top smma_checker u_smma_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .last_element_i (last_element_i),
  .result_valid_o (result_valid_o),
  .last_result_o  (last_result_o)
);

`default_nettype wire
